// ----- rtl/fcf_pkg.sv -----
// ----------------------------------------------------------------------------
// fcf_pkg: shared types for the FIR convolution filter
// Payload structs for the item channels and the control word of a tap cell.
// ----------------------------------------------------------------------------
package fcf_pkg;

    localparam int unsigned DATA_W    = 16;
    localparam int unsigned COEF_IDX_W = 6;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 7;
    localparam int unsigned TAP_CNT_W = 7;
    localparam int unsigned SHIFT_W   = 5;
    localparam int unsigned PROD_W    = 2 * DATA_W;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SHIFT = 2'd1;

    // Request codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    typedef struct packed {
        logic                         req_type;
        logic [COEF_IDX_W-1:0]        coef_index;
        logic signed [DATA_W-1:0]     value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0]     filtered_sample;
        logic                         saturated;
    } t_out_item;

    // Control word broadcast to every tap cell
    typedef struct packed {
        logic shift_in;   // push a new sample down the history
        logic rotate;     // hand coefficient and sample to the lower neighbor
    } t_cell_ctl;

endpackage

// ----- rtl/fcf_cell.sv -----
// ----------------------------------------------------------------------------
// fcf_cell: one tap of the filter chain
// Holds one coefficient and one history sample; shifts history in from the
// newer neighbor's side and rotates its pair toward the chain head.
// ----------------------------------------------------------------------------
module fcf_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fcf_pkg::t_cell_ctl            i_ctl,
    input  logic                          i_coef_wr,
    input  logic signed [fcf_pkg::DATA_W-1:0] i_coef_data,
    input  logic signed [fcf_pkg::DATA_W-1:0] i_x_prev,
    input  logic signed [fcf_pkg::DATA_W-1:0] i_c_next,
    input  logic signed [fcf_pkg::DATA_W-1:0] i_x_next,
    output logic signed [fcf_pkg::DATA_W-1:0] o_c,
    output logic signed [fcf_pkg::DATA_W-1:0] o_x
);
    import fcf_pkg::*;

    logic signed [DATA_W-1:0] r_c, n_c;
    logic signed [DATA_W-1:0] r_x, n_x;

    // Select the next coefficient and sample
    always_comb begin
        n_c = r_c;
        n_x = r_x;
        if (i_ctl.rotate) begin
            n_c = i_c_next;
            n_x = i_x_next;
        end else if (i_ctl.shift_in) begin
            n_x = i_x_prev;
        end else if (i_coef_wr) begin
            n_c = i_coef_data;
        end
    end

    // Hold tap state; reset clears coefficient and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= '0;
            r_x <= '0;
        end else begin
            r_c <= n_c;
            r_x <= n_x;
        end
    end

    assign o_c = r_c;
    assign o_x = r_x;

endmodule

// ----- rtl/fcf_mac.sv -----
// ----------------------------------------------------------------------------
// fcf_mac: multiply-accumulate at the head of the chain
// Registers one 16x16 product per cycle, then adds it into a wide sum.
// ----------------------------------------------------------------------------
module fcf_mac #(
    parameter int unsigned ACC_W = 39
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_en,
    input  logic signed [fcf_pkg::DATA_W-1:0] i_coef,
    input  logic signed [fcf_pkg::DATA_W-1:0] i_sample,
    output logic                          o_busy,
    output logic signed [ACC_W-1:0]       o_acc
);
    import fcf_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_en;
    logic signed [ACC_W-1:0]  r_acc;

    // Product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_en <= 1'b0;
        end else begin
            r_prod_en <= i_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * i_sample;
    end

    // Accumulate stage; clear starts a new sum
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_prod_en) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_busy = r_prod_en;
    assign o_acc  = r_acc;

endmodule

// ----- rtl/fir_convolution_filter.sv -----
// ----------------------------------------------------------------------------
// fir_convolution_filter: streaming direct-form FIR on Q1.15 data
//
//   channel | direction | handshake          | beat
//   in      | input     | i_in_valid/o_in_stall  | t_in_item (sample or tap write)
//   out     | output    | o_out_valid/i_out_stall | t_out_item (filtered sample)
//   cfg     | input     | i_cfg_valid/o_cfg_ready | register index + data
//
// A sample is handled in steps: the beat is taken, the cell chain rotates
// once through all TAPS cells past the single multiply-accumulate at its
// head, the product register drains, and the sum is shifted, saturated and
// loaded into the output register.
// Reset clears coefficients, history and all control at once.
// The output register holds a result while i_out_stall is high; a finished
// sum waits for it to empty, and the input stays stalled meanwhile.
// ----------------------------------------------------------------------------
module fir_convolution_filter #(
    parameter int unsigned TAPS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  fcf_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output fcf_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fcf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fcf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import fcf_pkg::*;

    localparam int unsigned ACC_W = PROD_W + $clog2(TAPS + 1) + 1;
    localparam int unsigned CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TAPS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ROTATE = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_step, n_step;
    logic [TAP_CNT_W-1:0]    r_tap_count;
    logic [SHIFT_W-1:0]      r_shift;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out_data;

    logic                    w_in_acc, w_sample_acc, w_coef_acc, w_out_load;
    logic                    w_use_tap, w_mac_busy;
    t_cell_ctl               w_ctl;
    logic signed [DATA_W-1:0] w_c [TAPS];
    logic signed [DATA_W-1:0] w_x [TAPS];
    logic signed [ACC_W-1:0] w_acc, w_shifted;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_sample_acc = w_in_acc && (i_in_data.req_type == REQ_SAMPLE);
    assign w_coef_acc   = w_in_acc && (i_in_data.req_type == REQ_COEF);

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_CNT_W'(64);
            r_shift     <= SHIFT_W'(15);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TAP_COUNT:    r_tap_count <= i_cfg_data;
                CFG_OUTPUT_SHIFT: r_shift     <= i_cfg_data[SHIFT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Chain control
    assign w_ctl.shift_in = w_sample_acc;
    assign w_ctl.rotate   = (r_state == ST_ROTATE);
    assign w_use_tap      = (r_state == ST_ROTATE) && (32'(r_step) < 32'(r_tap_count));

    // Row of tap cells; cell 0 is the chain head
    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        fcf_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_coef_wr   (w_coef_acc && (32'(i_in_data.coef_index) == k)),
            .i_coef_data (i_in_data.value),
            .i_x_prev    ((k == 0) ? i_in_data.value : w_x[(k == 0) ? 0 : k - 1]),
            .i_c_next    (w_c[(k + 1) % TAPS]),
            .i_x_next    (w_x[(k + 1) % TAPS]),
            .o_c         (w_c[k]),
            .o_x         (w_x[k])
        );
    end

    fcf_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_sample_acc),
        .i_en     (w_use_tap),
        .i_coef   (w_c[0]),
        .i_sample (w_x[0]),
        .o_busy   (w_mac_busy),
        .o_acc    (w_acc)
    );

    // Shift and clip the finished sum
    assign w_shifted  = w_acc >>> r_shift;
    assign w_out_load = (r_state == ST_FINISH) && !(r_out_valid && i_out_stall);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (w_sample_acc) n_state = ST_ROTATE;
            end
            ST_ROTATE: begin
                if (r_step == LAST_STEP) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_step = r_step + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (w_out_load) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (w_shifted > SAT_MAX) begin
                r_out_data.filtered_sample <= 16'sh7fff;
                r_out_data.saturated       <= 1'b1;
            end else if (w_shifted < SAT_MIN) begin
                r_out_data.filtered_sample <= 16'sh8000;
                r_out_data.saturated       <= 1'b1;
            end else begin
                r_out_data.filtered_sample <= w_shifted[DATA_W-1:0];
                r_out_data.saturated       <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A sample starts a full rotation from the chain head
    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sample_acc |=> (r_state == ST_ROTATE) && (r_step == '0))
        else $error("sample did not start a rotation");

    // Draining follows a complete rotation
    a_full_rotation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_step == LAST_STEP))
        else $error("rotation ended early");

    // No product is pending once the sum is read
    a_mac_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH || r_state == ST_IDLE) |-> !w_mac_busy)
        else $error("product still pending at finish");

    // A free output register takes the result at once
    a_finish_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && !r_out_valid) |=> r_out_valid && (r_state == ST_IDLE))
        else $error("result not loaded");

    // A tap write keeps the block idle
    a_coef_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_coef_acc |=> (r_state == ST_IDLE))
        else $error("tap write left idle");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the FIR convolution filter
// Drives tap writes and samples through the stall-handshake input channel.
// A software copy of the filter tracks taps, history and registers, and
// predicts each filtered sample. Every output beat is compared field by
// field. Register settings, idle and stall rates change from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;

    import fcf_pkg::*;

    localparam int unsigned TAPS        = 64;
    localparam int unsigned NUM_PHASES  = 7;
    localparam int unsigned PHASE_ITEMS = 150;
    localparam int unsigned SETTLE_CYC  = TAPS + 12;
    localparam int unsigned HOLD_CYC    = 400;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    // ------------------------------------------------------------------------
    // Filter tracker: taps, sample history and registers, plus the queue of
    // filtered samples still owed by the block
    // ------------------------------------------------------------------------
    class fir_tracker;
        logic signed [DATA_W-1:0] taps    [TAPS];
        logic signed [DATA_W-1:0] history [TAPS-1];
        int unsigned              taps_used;
        int unsigned              out_shift;
        t_out_item                owed_q [$];
        int unsigned              errors;

        function new();
            foreach (taps[k]) taps[k] = '0;
            foreach (history[k]) history[k] = '0;
            taps_used = 64;
            out_shift = 15;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TAP_COUNT:    taps_used = data[TAP_CNT_W-1:0];
                CFG_OUTPUT_SHIFT: out_shift = data[SHIFT_W-1:0];
                default: ;
            endcase
        endfunction

        // Convolve the new sample with the history, then advance the history
        function t_out_item filter_sample(logic signed [DATA_W-1:0] x);
            t_out_item   res;
            longint      acc;
            longint      y;
            int unsigned n;
            acc = 0;
            n   = (taps_used > TAPS) ? TAPS : taps_used;
            for (int unsigned k = 0; k < n; k++) begin
                if (k == 0)
                    acc += longint'(taps[0]) * longint'(x);
                else
                    acc += longint'(taps[k]) * longint'(history[k-1]);
            end
            for (int k = TAPS - 2; k > 0; k--) history[k] = history[k-1];
            history[0] = x;
            // arithmetic shift rounds toward minus infinity
            y = acc >>> out_shift;
            res.saturated = 1'b0;
            if (y > 32767) begin
                y = 32767;
                res.saturated = 1'b1;
            end else if (y < -32768) begin
                y = -32768;
                res.saturated = 1'b1;
            end
            res.filtered_sample = y[DATA_W-1:0];
            return res;
        endfunction

        function void note_beat(t_in_item it);
            if (it.req_type == REQ_COEF) begin
                if (it.coef_index < TAPS) taps[it.coef_index] = it.value;
            end else begin
                owed_q.push_back(filter_sample(it.value));
            end
        endfunction

        function void check_beat(t_out_item got);
            t_out_item want;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected output beat: filtered_sample %0d saturated %0b",
                         $time, got.filtered_sample, got.saturated);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.filtered_sample !== want.filtered_sample) begin
                $display("%0t: filtered_sample expected %0d actual %0d",
                         $time, want.filtered_sample, got.filtered_sample);
                errors++;
            end
            if (got.saturated !== want.saturated) begin
                $display("%0t: saturated expected %0b actual %0b",
                         $time, want.saturated, got.saturated);
                errors++;
            end
        endfunction

        function int unsigned owed();
            return owed_q.size();
        endfunction

        function void flag_leftover();
            if (owed_q.size() != 0) begin
                $display("%0t: %0d filtered samples never arrived", $time, owed_q.size());
                errors += owed_q.size();
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fir_tracker  tracker = new();
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned hold_off_len;
    int unsigned cycle_cnt;

    fir_convolution_filter #(
        .TAPS(TAPS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // End the run if it hangs
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver stall: random rate, or a long hold-off when one is requested
    initial begin
        int unsigned hold_cnt;
        hold_cnt    = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_len != 0) begin
                hold_cnt     = hold_off_len;
                hold_off_len = 0;
            end
            if (hold_cnt != 0) begin
                i_out_stall <= 1'b1;
                hold_cnt--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
            end
        end
    end

    // Check every output beat taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) tracker.check_beat(o_out_data);
    end

    // ------------------------------------------------------------------------
    // Driver tasks; each is entered and left just after a falling edge
    // ------------------------------------------------------------------------
    function automatic t_in_item make_item(logic req, logic [COEF_IDX_W-1:0] idx,
                                           logic signed [DATA_W-1:0] v);
        t_in_item it;
        it.req_type   = req;
        it.coef_index = idx;
        it.value      = v;
        return it;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_in_item random_item();
        if ($urandom_range(0, 3) == 0)
            return make_item(REQ_COEF, COEF_IDX_W'($urandom_range(0, TAPS - 1)),
                             pick_value());
        return make_item(REQ_SAMPLE, COEF_IDX_W'($urandom_range(0, 63)), pick_value());
    endfunction

    // Offer one beat after a random gap; hold it until taken
    task automatic push_item(input t_in_item it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_beat(it);
        @(negedge i_clk);
    endtask

    // Leave valid high; the caller drops it after the last write
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (tracker.owed() != 0) @(negedge i_clk);
    endtask

    // Stop input, wait for all owed samples and let a trailing tap write finish
    task automatic settle();
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned tc;
        int unsigned sh;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_off_len   = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed beats at the reset settings: empty taps, saturation both
        // ways, floor rounding of a small negative sum, extreme indexes
        push_item(make_item(REQ_SAMPLE, 6'd0,  16'sh7FFF));
        push_item(make_item(REQ_COEF,   6'd0,  16'sh8000));
        push_item(make_item(REQ_COEF,   6'd63, 16'sh7FFF));
        push_item(make_item(REQ_SAMPLE, 6'd63, 16'sh8000));
        push_item(make_item(REQ_SAMPLE, 6'd0,  16'sh7FFF));
        push_item(make_item(REQ_COEF,   6'd1,  16'sh8000));
        push_item(make_item(REQ_SAMPLE, 6'd0,  16'sh7FFF));
        push_item(make_item(REQ_SAMPLE, 6'd0,  16'sh0000));
        push_item(make_item(REQ_SAMPLE, 6'd0,  16'shFFFF));
        push_item(make_item(REQ_COEF,   6'd0,  16'sh7FFF));
        push_item(make_item(REQ_COEF,   6'd1,  16'sh0000));
        push_item(make_item(REQ_SAMPLE, 6'd0,  16'sh0001));
        push_item(make_item(REQ_SAMPLE, 6'd0,  16'shFFFF));
        push_item(make_item(REQ_COEF,   6'd42, 16'sh5555));
        push_item(make_item(REQ_SAMPLE, 6'd21, 16'shAAAA));
        push_item(make_item(REQ_SAMPLE, 6'd0,  16'sh5555));
        settle();

        // Random phases: register setting and idle mode change each time
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       begin tc = 1;   sh = 0;  end
                1:       begin tc = 64;  sh = 31; end
                2:       begin tc = 0;   sh = 15; end
                3:       begin tc = 127; sh = 16; end
                4:       begin tc = $urandom_range(1, TAPS); sh = $urandom_range(0, 31); end
                5:       begin tc = 64;  sh = 15; end
                default: begin tc = $urandom_range(0, 127);  sh = 14; end
            endcase
            write_register(CFG_TAP_COUNT, tc[CFG_DATA_W-1:0]);
            write_register(CFG_OUTPUT_SHIFT, sh[CFG_DATA_W-1:0]);
            i_cfg_valid <= 1'b0;
            case (p % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 48; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 48; end
                default: begin src_idle_pct = 32; sink_stall_pct = 32; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold-off while the sender keeps offering
                if (p == 0 && n == 30) hold_off_len = HOLD_CYC;
                // sender pause until the block has delivered everything
                if (p == 4 && n == 60) begin
                    i_in_valid <= 1'b0;
                    wait_drained();
                    @(negedge i_clk);
                end
                push_item(random_item());
            end
            settle();
        end

        tracker.flag_leftover();
        if (tracker.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
